// ===== rtl/sfp_pkg.sv =====
// Shared types, constants and decode functions for the sensor frame parser.
// No dependencies; imported by sfp_parser, sfp_emitter and the top level.
package sfp_pkg;

    // Only the first twelve payload bytes are ever decoded (id 3 reads 0..11).
    localparam int KEEP_BYTES = 12;

    localparam logic [7:0] SYNC_BYTE = 8'h55;

    localparam logic [7:0] KIND_01 = 8'h01;
    localparam logic [7:0] KIND_02 = 8'h02;
    localparam logic [7:0] KIND_03 = 8'h03;
    localparam logic [7:0] KIND_04 = 8'h04;
    localparam logic [7:0] KIND_05 = 8'h05;
    localparam logic [7:0] KIND_06 = 8'h06;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_KIND,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef enum logic [1:0] {
        ST_VALUE   = 2'd0,
        ST_SUM_ERR = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef logic [7:0] byte_t;
    typedef byte_t [KEEP_BYTES-1:0] payload_t;

    // Finished frame handed from parser to emitter.
    typedef struct packed {
        logic        ok;
        logic [7:0]  kind;
        payload_t    bytes;
        logic [31:0] good;
        logic [31:0] bad;
    } frame_t;

    // Number of decoded values for an id; zero for an unknown id.
    function automatic logic [2:0] value_count(input logic [7:0] kind);
        logic [2:0] n;
        case (kind)
            KIND_01: n = 3'd3;
            KIND_02: n = 3'd4;
            KIND_03: n = 3'd6;
            KIND_04: n = 3'd4;
            KIND_05: n = 3'd3;
            KIND_06: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Little-endian value idx of a frame of the given id.
    function automatic logic [31:0] decode_value(input logic [7:0] kind,
                                                 input logic [2:0] idx,
                                                 input payload_t   b);
        logic [15:0] pair;
        logic [31:0] res;
        case (idx)
            3'd0:    pair = {b[1],  b[0]};
            3'd1:    pair = {b[3],  b[2]};
            3'd2:    pair = {b[5],  b[4]};
            3'd3:    pair = {b[7],  b[6]};
            3'd4:    pair = {b[9],  b[8]};
            3'd5:    pair = {b[11], b[10]};
            default: pair = 16'd0;
        endcase
        if (kind == KIND_05) begin
            // two 32-bit words, then a signed 16-bit word at byte 8
            case (idx)
                3'd0:    res = {b[3], b[2], b[1], b[0]};
                3'd1:    res = {b[7], b[6], b[5], b[4]};
                default: res = {{16{b[9][7]}}, b[9], b[8]};
            endcase
        end else if (kind == KIND_06) begin
            res = {16'd0, pair};
        end else begin
            res = {{16{pair[15]}}, pair};
        end
        return res;
    endfunction

endpackage

// ===== rtl/sfp_parser.sv =====
// Byte-level frame hunter: sync, id, length, data capture, checksum, counts.
// Depends on sfp_pkg; hands finished frames to sfp_emitter.
module sfp_parser #(
    parameter int PAYLOAD_BYTES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      rx_byte,
    input  logic            can_load,
    output logic            frame_valid,
    output sfp_pkg::frame_t frame
);
    import sfp_pkg::*;

    localparam int LEN_W = $clog2(PAYLOAD_BYTES + 1);

    phase_t            phase_reg, phase_next;
    logic [7:0]        kind_reg, kind_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  taken_reg, taken_next;
    logic [7:0]        sum_reg, sum_next;
    payload_t          payload_reg;
    logic [31:0]       good_reg, good_next;
    logic [31:0]       bad_reg, bad_next;
    logic              accept;
    logic              sum_ok;
    logic [LEN_W-1:0]  taken_inc;

    // checksum byte waits until the emitter can take the frame
    assign in_ready = (phase_reg != PH_SUM) || can_load;
    assign accept   = in_valid && in_ready;
    assign sum_ok   = (rx_byte == sum_reg);
    assign taken_inc = taken_reg + 1'b1;

    assign frame_valid = accept && (phase_reg == PH_SUM);
    assign frame.ok    = sum_ok;
    assign frame.kind  = kind_reg;
    assign frame.bytes = payload_reg;
    assign frame.good  = good_next;
    assign frame.bad   = bad_next;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        length_next = length_reg;
        taken_next  = taken_reg;
        sum_next    = sum_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;
        case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == SYNC_BYTE) begin
                    sum_next   = SYNC_BYTE;
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_BYTE) begin
                    sum_next   = sum_reg + SYNC_BYTE;
                    phase_next = PH_KIND;
                end else begin
                    phase_next = PH_SYNC1;
                    taken_next = '0;
                    sum_next   = '0;
                end
            end
            PH_KIND:
            begin
                kind_next  = rx_byte;
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (rx_byte == 8'd0 || rx_byte > 8'(PAYLOAD_BYTES)) begin
                    phase_next = PH_SYNC1;
                    taken_next = '0;
                    sum_next   = '0;
                end else begin
                    length_next = rx_byte[LEN_W-1:0];
                    sum_next    = sum_reg + rx_byte;
                    taken_next  = '0;
                    phase_next  = PH_DATA;
                end
            end
            PH_DATA:
            begin
                taken_next = taken_inc;
                sum_next   = sum_reg + rx_byte;
                if (taken_inc >= length_reg) begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                if (sum_ok) begin
                    good_next = good_reg + 32'd1;
                end else begin
                    bad_next = bad_reg + 32'd1;
                end
                phase_next = PH_SYNC1;
                taken_next = '0;
                sum_next   = '0;
            end
            default:
            begin
                phase_next = PH_SYNC1;
                taken_next = '0;
                sum_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_SYNC1;
            kind_reg   <= '0;
            length_reg <= '0;
            taken_reg  <= '0;
            sum_reg    <= '0;
            good_reg   <= '0;
            bad_reg    <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            length_reg <= length_next;
            taken_reg  <= taken_next;
            sum_reg    <= sum_next;
            good_reg   <= good_next;
            bad_reg    <= bad_next;
        end
    end

    // Bytes past the decoded window are never read back; drop them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            payload_reg <= '0;
        end else if (accept && phase_reg == PH_DATA) begin
            for (int i = 0; i < KEEP_BYTES; i++) begin
                if (taken_reg == LEN_W'(i)) begin
                    payload_reg[i] <= rx_byte;
                end
            end
        end
    end

endmodule

// ===== rtl/sfp_emitter.sv =====
// Result stage: snapshots a finished frame and issues its results in order.
// Depends on sfp_pkg for frame_t and the decode functions.
module sfp_emitter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            frame_valid,
    input  sfp_pkg::frame_t frame,
    output logic            can_load,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      status,
    output logic [7:0]      frame_kind,
    output logic [2:0]      value_index,
    output logic [31:0]     value,
    output logic            last,
    output logic [31:0]     good_frames,
    output logic [31:0]     bad_frames
);
    import sfp_pkg::*;

    logic        valid_reg;
    status_t     status_reg;
    logic [7:0]  kind_reg;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] value_reg;
    logic        last_reg;
    logic [31:0] good_reg;
    logic [31:0] bad_reg;
    payload_t    bytes_reg;
    logic [2:0]  count_reg, count_next;
    logic        advance;
    logic        has_values;

    assign advance    = valid_reg && out_ready && !last_reg;
    assign can_load   = !valid_reg || (out_ready && last_reg);
    assign idx_next   = idx_reg + 3'd1;
    assign count_next = value_count(frame.kind);
    assign has_values = frame.ok && (count_next != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (frame_valid) begin
            valid_reg <= 1'b1;
        end else if (valid_reg && out_ready && last_reg) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid) begin
            kind_reg  <= frame.kind;
            bytes_reg <= frame.bytes;
            good_reg  <= frame.good;
            bad_reg   <= frame.bad;
            count_reg <= count_next;
            idx_reg   <= 3'd0;
            last_reg  <= !has_values;
            if (!frame.ok) begin
                status_reg <= ST_SUM_ERR;
                value_reg  <= 32'd0;
            end else if (count_next == 3'd0) begin
                status_reg <= ST_UNKNOWN;
                value_reg  <= 32'd0;
            end else begin
                status_reg <= ST_VALUE;
                value_reg  <= decode_value(frame.kind, 3'd0, frame.bytes);
            end
        end else if (advance) begin
            idx_reg   <= idx_next;
            value_reg <= decode_value(kind_reg, idx_next, bytes_reg);
            last_reg  <= (idx_next == count_reg - 3'd1);
        end
    end

    assign out_valid   = valid_reg;
    assign status      = status_reg;
    assign frame_kind  = kind_reg;
    assign value_index = idx_reg;
    assign value       = value_reg;
    assign last        = last_reg;
    assign good_frames = good_reg;
    assign bad_frames  = bad_reg;

endmodule

// ===== rtl/sensor_frame_parser_sum_check.sv =====
// Sensor frame parser with 8-bit additive checksum, top level.
// Throughput: one rx byte per cycle; a checksum byte waits only while the previous
// frame's results are still leaving. A frame's results (up to six) start the cycle
// after its checksum byte is taken and go out one per cycle while out_ready holds.
// Reset (rst_n, async, active low) restarts the hunt and clears counts and payload.
// Depends on sfp_pkg, sfp_parser and sfp_emitter.
module sensor_frame_parser_sum_check #(
    parameter int PAYLOAD_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // rx word channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // result word channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  frame_kind,
    output logic [2:0]  value_index,
    output logic [31:0] value,
    output logic        last,
    output logic [31:0] good_frames,
    output logic [31:0] bad_frames
);
    import sfp_pkg::*;

    // Frame hand-off between the byte parser and the result stage.
    // The emitter snapshots the payload window, so the parser is free to
    // collect the next frame's bytes while results drain.
    logic   frame_valid;
    frame_t frame;
    logic   can_load;

    // Parser: one byte per accepted word. Holds phase, id, length, running
    // sum, the decoded payload window and the good/bad counters.
    sfp_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .can_load    (can_load),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    // Emitter: result register plus value index; walks the id's value list.
    sfp_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .frame_kind  (frame_kind),
        .value_index (value_index),
        .value       (value),
        .last        (last),
        .good_frames (good_frames),
        .bad_frames  (bad_frames)
    );

    // Stalling the input implies a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // Error and unknown-id results are single, zero-valued words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_VALUE) |-> (last && value == 32'd0 && value_index == 3'd0))
        else $error("error or unknown-id result malformed");

    // Value index stays within the longest value list.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (value_index <= 3'd5))
        else $error("value index out of range");

    // A non-final result is followed by the next index of the same frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=>
            (out_valid && value_index == $past(value_index) + 3'd1))
        else $error("result sequence broken");

endmodule

// ===== tb/tb_sensor_frame_parser_sum_check.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sensor frame parser with additive checksum.
// Depends on sfp_pkg and sensor_frame_parser_sum_check; needs no files or arguments.
module tb_sensor_frame_parser_sum_check;

    import sfp_pkg::*;

    localparam int PAYLOAD_LEN  = 16;     // maximum payload length of the instance
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off for the backpressure test
    localparam int DRAIN_LIMIT  = 5000;   // cycles allowed for leftover results at the end
    localparam int SETTLE_CYCLES = 20;    // quiet cycles after the last result

    // Ids outside the decoded set, one on each side of it.
    localparam logic [7:0] KIND_NONE     = 8'h00;
    localparam logic [7:0] KIND_PAST_END = 8'h07;

    // One result word as the block presents it.
    typedef struct {
        status_t     st;
        logic [7:0]  kind;
        logic [2:0]  idx;
        logic [31:0] val;
        logic        lst;
        logic [31:0] good;
        logic [31:0] bad;
    } result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  status;
    logic [7:0]  frame_kind;
    logic [2:0]  value_index;
    logic [31:0] value;
    logic        last;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;

    // Idle percentages for each side; changed between test phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count     = 0;
    int words_sent    = 0;

    // Long hold-off of the receiver, counted in its own process.
    event hold_start;
    logic hold_active = 1'b0;

    // Results still owed by the block, oldest first.
    result_t expected_results [$];

    // Shadow copy of the parser state, reset values included.
    phase_t      hunt_phase = PH_SYNC1;
    logic [7:0]  held_kind  = 8'h00;
    logic [4:0]  held_len   = 5'd0;
    logic [4:0]  taken      = 5'd0;
    logic [7:0]  sum_acc    = 8'h00;
    logic [7:0]  payload_copy [PAYLOAD_LEN] = '{default: 8'h00};
    logic [31:0] good_tally = 32'd0;
    logic [31:0] bad_tally  = 32'd0;

    logic [7:0]  known_kinds [6] = '{KIND_01, KIND_02, KIND_03, KIND_04, KIND_05, KIND_06};

    sensor_frame_parser_sum_check #(
        .PAYLOAD_BYTES(PAYLOAD_LEN)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .frame_kind  (frame_kind),
        .value_index (value_index),
        .value       (value),
        .last        (last),
        .good_frames (good_frames),
        .bad_frames  (bad_frames)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // Result fields that do not depend on the value come from the held id
    // and the counts as they stand after this checksum byte.
    function automatic void queue_result(input status_t st, input int idx,
                                         input logic [31:0] val, input logic lst);
        result_t r;
        r.st   = st;
        r.kind = held_kind;
        r.idx  = idx[2:0];
        r.val  = val;
        r.lst  = lst;
        r.good = good_tally;
        r.bad  = bad_tally;
        expected_results.push_back(r);
    endfunction

    // Restart of the hunt: id, length and stored payload survive.
    function automatic void drop_to_hunt();
        hunt_phase = PH_SYNC1;
        taken      = 5'd0;
        sum_acc    = 8'h00;
    endfunction

    // Decoded values of a frame that passed its checksum. Bytes beyond the
    // frame's own length are whatever the payload store still holds.
    function automatic void queue_decoded();
        int          n;
        logic [31:0] w;
        case (held_kind)
            KIND_01:                   n = 3;
            KIND_02, KIND_04, KIND_06: n = 4;
            KIND_03:                   n = 6;
            KIND_05:                   n = 3;
            default:                   n = 0;
        endcase
        if (n == 0) begin
            queue_result(ST_UNKNOWN, 0, 32'd0, 1'b1);
            return;
        end
        for (int k = 0; k < n; k++) begin
            if (held_kind == KIND_05) begin
                // two 32-bit words, then a signed 16-bit word at byte 8
                if (k < 2)
                    w = {payload_copy[4*k+3], payload_copy[4*k+2],
                         payload_copy[4*k+1], payload_copy[4*k]};
                else
                    w = {{16{payload_copy[9][7]}}, payload_copy[9], payload_copy[8]};
            end else if (held_kind == KIND_06) begin
                w = {16'h0000, payload_copy[2*k+1], payload_copy[2*k]};
            end else begin
                w = {{16{payload_copy[2*k+1][7]}}, payload_copy[2*k+1], payload_copy[2*k]};
            end
            queue_result(ST_VALUE, k, w, (k == n - 1));
        end
    endfunction

    // Advance the shadow parser by one accepted rx word.
    function automatic void absorb_rx_byte(input logic [7:0] b);
        case (hunt_phase)
            PH_SYNC1: begin
                if (b == SYNC_BYTE) begin
                    sum_acc    = SYNC_BYTE;
                    hunt_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (b == SYNC_BYTE) begin
                    sum_acc    = sum_acc + SYNC_BYTE;
                    hunt_phase = PH_KIND;
                end else begin
                    drop_to_hunt();
                end
            end
            PH_KIND: begin
                held_kind  = b;
                sum_acc    = sum_acc + b;
                hunt_phase = PH_LEN;
            end
            PH_LEN: begin
                if (b == 8'h00 || b > PAYLOAD_LEN) begin
                    drop_to_hunt();
                end else begin
                    held_len   = b[4:0];
                    sum_acc    = sum_acc + b;
                    taken      = 5'd0;
                    hunt_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (taken < PAYLOAD_LEN)
                    payload_copy[taken[3:0]] = b;
                taken   = taken + 5'd1;
                sum_acc = sum_acc + b;
                if (taken >= held_len)
                    hunt_phase = PH_SUM;
            end
            PH_SUM: begin
                if (b == sum_acc) begin
                    good_tally = good_tally + 32'd1;
                    queue_decoded();
                end else begin
                    bad_tally = bad_tally + 32'd1;
                    queue_result(ST_SUM_ERR, 0, 32'd0, 1'b1);
                end
                drop_to_hunt();
            end
            default: drop_to_hunt();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver side
    // ------------------------------------------------------------------

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endfunction

    // Checks every result word taken at this edge, then picks out_ready for
    // the next cycle: held low during a hold-off, random idling otherwise.
    always @(posedge clk) begin : result_check
        result_t want;
        if (out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected result word, expected none, %s %0h %0h %0h",
                         $time, "actual status kind value", status, frame_kind, value);
            end else begin
                want = expected_results.pop_front();
                compare_field("status",      want.st,   status);
                compare_field("frame_kind",  want.kind, frame_kind);
                compare_field("value_index", want.idx,  value_index);
                compare_field("value",       want.val,  value);
                compare_field("last",        want.lst,  last);
                compare_field("good_frames", want.good, good_frames);
                compare_field("bad_frames",  want.bad,  bad_frames);
            end
        end
        if (hold_active)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold-off process: starts on request, counts its own cycles.
    initial begin : hold_control
        forever begin
            @(hold_start);
            @(posedge clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one rx word and wait for the handshake. Called at a rising edge;
    // returns at the edge that took the word, with valid still high so a
    // following word goes out back to back unless an idle cycle is drawn.
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        absorb_rx_byte(b);
        words_sent++;
    endtask

    // Full frame: two sync words, id, length, data and the sum. A corrupted
    // frame has a nonzero offset added to its sum word.
    task automatic send_frame(input logic [7:0] kind, input int len,
                              input logic [7:0] data [PAYLOAD_LEN], input bit corrupt);
        logic [7:0] s;
        logic [7:0] skew;
        s = SYNC_BYTE + SYNC_BYTE + kind + len[7:0];
        send_word(SYNC_BYTE);
        send_word(SYNC_BYTE);
        send_word(kind);
        send_word(len[7:0]);
        for (int i = 0; i < len; i++) begin
            s = s + data[i];
            send_word(data[i]);
        end
        if (corrupt) begin
            skew = 8'($urandom_range(255, 1));
            s    = s + skew;
        end
        send_word(s);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hunt restarts, a short frame read against the cleared store, an
    // unknown id with a good sum and a checksum error.
    task automatic test_directed_frames();
        logic [7:0] d [PAYLOAD_LEN];
        foreach (d[i]) d[i] = 8'h00;
        // second header word wrong
        send_word(SYNC_BYTE);
        send_word(8'hAA);
        // zero length, then one past the longest legal length
        send_word(SYNC_BYTE);
        send_word(SYNC_BYTE);
        send_word(KIND_PAST_END);
        send_word(8'h00);
        send_word(SYNC_BYTE);
        send_word(SYNC_BYTE);
        send_word(KIND_PAST_END);
        send_word(8'h11);
        // one data word for id 5: the rest of its values come from zeros
        d[0] = 8'h80;
        send_frame(KIND_05, 1, d, 1'b0);
        // unknown id, all-ones data word, good sum
        d[0] = 8'hFF;
        send_frame(8'hFF, 1, d, 1'b0);
        // checksum error on an id-zero frame
        d[0] = 8'h00;
        send_frame(KIND_NONE, 1, d, 1'b1);
    endtask

    // Mostly well-formed frames with random content; the rest broken headers,
    // bad lengths and raw noise, which also leave frames cut short.
    task automatic test_random_traffic(input int n_words);
        logic [7:0] d [PAYLOAD_LEN];
        logic [7:0] kind;
        logic [7:0] nb;
        int         start;
        int         pick;
        int         len;
        start = words_sent;
        while (words_sent - start < n_words) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                pick = $urandom_range(9);
                if (pick < 6)
                    kind = known_kinds[pick];
                else if (pick == 6)
                    kind = KIND_NONE;
                else if (pick == 7)
                    kind = KIND_PAST_END;
                else
                    kind = 8'($urandom_range(255));
                // length the id needs, or any legal length now and then
                case (kind)
                    KIND_01:                   len = 6;
                    KIND_02, KIND_04, KIND_06: len = 8;
                    KIND_03:                   len = 12;
                    KIND_05:                   len = 10;
                    default:                   len = $urandom_range(PAYLOAD_LEN, 1);
                endcase
                if ($urandom_range(3) == 0)
                    len = $urandom_range(PAYLOAD_LEN, 1);
                foreach (d[i]) d[i] = 8'($urandom_range(255));
                send_frame(kind, len, d, ($urandom_range(99) < 15));
            end else if (pick < 90) begin
                send_word(SYNC_BYTE);
                if ($urandom_range(1) == 0) begin
                    nb = 8'($urandom_range(255));
                    if (nb == SYNC_BYTE)
                        nb = ~nb;
                    send_word(nb);
                end else begin
                    send_word(SYNC_BYTE);
                    nb = 8'($urandom_range(255));
                    send_word(nb);
                    if ($urandom_range(1) == 0)
                        nb = 8'h00;
                    else
                        nb = 8'($urandom_range(255, PAYLOAD_LEN + 1));
                    send_word(nb);
                end
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    if ($urandom_range(3) == 0)
                        nb = SYNC_BYTE;
                    else
                        nb = 8'($urandom_range(255));
                    send_word(nb);
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while full id-3 frames keep
    // coming, so results back up and the block stalls its rx channel.
    task automatic test_result_backpressure();
        logic [7:0] d [PAYLOAD_LEN];
        -> hold_start;
        repeat (4) begin
            foreach (d[i]) d[i] = 8'($urandom_range(255));
            send_frame(KIND_03, 12, d, 1'b0);
        end
        // longest legal frame as well
        foreach (d[i]) d[i] = 8'($urandom_range(255));
        send_frame(KIND_02, PAYLOAD_LEN, d, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : main_sequence
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 23;
        recv_idle_pct = 87;
        test_directed_frames();
        test_random_traffic(70);

        // the other way round
        send_idle_pct = 87;
        recv_idle_pct = 23;
        test_random_traffic(70);

        // no idling at all, then the long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(50);
        test_result_backpressure();

        in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            err_count++;
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, expected_results.size());
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin : watchdog
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
